>>> rtl/lagged_linear_convolution_macros.svh
// ----------------------------------------------------------------------------
// Lagged linear convolution assertion macros
// Concurrent check wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LAGGED_LINEAR_CONVOLUTION_MACROS_SVH
`define LAGGED_LINEAR_CONVOLUTION_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llc: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llc: next-cycle check failed");

`endif

>>> rtl/llc_pkg.sv
// ----------------------------------------------------------------------------
// llc_pkg
// Shared widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package llc_pkg;

  localparam int unsigned MAX_WAVE_DEF  = 4096;
  localparam int unsigned MAX_PULSE_DEF = 2048;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned SMP_W    = 24;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned WLEN_W   = 13;
  localparam int unsigned PLEN_W   = 12;
  localparam int unsigned OFF_W    = 14;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned REG_W    = 2;
  localparam int unsigned CDATA_W  = 16;

  // arithmetic widths
  localparam int unsigned PROD_W   = SMP_W + COEF_W;          // 42
  localparam int unsigned SUM_W    = PROD_W + WLEN_W - 1;     // 54, signed
  localparam int unsigned MAG_W    = SUM_W - 1;               // 53
  localparam int unsigned PLO_W    = 32 + GAIN_W;             // 48
  localparam int unsigned PHI_W    = MAG_W - 32 + GAIN_W;     // 37
  localparam int unsigned PSUM_W   = PHI_W + 32;              // 69
  localparam int unsigned FRAC_SH  = 26;
  localparam int unsigned Q_W      = PSUM_W - FRAC_SH;        // 43
  localparam int unsigned K_W      = 16;                      // pulse index, signed

  // ops
  localparam logic [OP_W-1:0] OP_LOAD_WAVE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_PULSE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ       = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PULSE_LONG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE      = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_WAVE_LEN  = 2'd0;
  localparam logic [REG_W-1:0] REG_PULSE_LEN = 2'd1;
  localparam logic [REG_W-1:0] REG_OFFSET    = 2'd2;
  localparam logic [REG_W-1:0] REG_GAIN      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_ABS,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } llc_state_t;

  typedef struct packed {
    logic load_wave;
    logic load_pulse;
    logic start;
    logic check;
    logic issue;
    logic abs_en;
    logic mul_en;
    logic add_en;
    logic emit;
  } llc_cmd_t;

  typedef struct packed {
    logic err;
    logic last_j;
    logic pipe_busy;
    logic rsp_free;
  } llc_stat_t;

endpackage

`default_nettype wire

>>> rtl/llc_req_if.sv
// ----------------------------------------------------------------------------
// llc_req_if
// Request channel: loads and reads.
// ----------------------------------------------------------------------------
`default_nettype none

interface llc_req_if
  import llc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         index;
  logic signed [SMP_W-1:0]  sample;

  modport source (output valid, op, index, sample, input ready);
  modport sink   (input valid, op, index, sample, output ready);
endinterface

`default_nettype wire

>>> rtl/llc_rsp_if.sv
// ----------------------------------------------------------------------------
// llc_rsp_if
// Response channel: one result per read.
// ----------------------------------------------------------------------------
`default_nettype none

interface llc_rsp_if
  import llc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  value;
  logic [IDX_W-1:0]         out_index;
  logic [STAT_W-1:0]        status;
  logic                     saturated;

  modport source (output valid, value, out_index, status, saturated, input ready);
  modport sink   (input valid, value, out_index, status, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/llc_cfg_if.sv
// ----------------------------------------------------------------------------
// llc_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface llc_cfg_if
  import llc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REG_W-1:0]    index;
  logic [CDATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/llc_ctrl.sv
// ----------------------------------------------------------------------------
// llc_ctrl
// Sequencer: request handling, MAC sweep, scaling steps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module llc_ctrl
  import llc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic [OP_W-1:0] req_op,
  output      logic            req_ready,
  input  wire llc_stat_t       stat,
  output      llc_cmd_t        cmd
);

  llc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_op == OP_READ) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.err ? ST_EMIT : ST_MAC;
      end
      ST_MAC: begin
        if (stat.last_j) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_ABS;
      end
      ST_ABS:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready      = 1'b1;
        cmd.load_wave  = req_valid && req_op == OP_LOAD_WAVE;
        cmd.load_pulse = req_valid && req_op == OP_LOAD_PULSE;
        cmd.start      = req_valid && req_op == OP_READ;
      end
      ST_CHECK: cmd.check  = 1'b1;
      ST_MAC:   cmd.issue  = 1'b1;
      ST_DRAIN: ;
      ST_ABS:   cmd.abs_en = 1'b1;
      ST_MUL:   cmd.mul_en = 1'b1;
      ST_ADD:   cmd.add_en = 1'b1;
      ST_EMIT:  cmd.emit   = stat.rsp_free;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/llc_dp.sv
// ----------------------------------------------------------------------------
// llc_dp
// Datapath: config registers, sample stores, MAC pipe, scaler, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module llc_dp
  import llc_pkg::*;
#(
  parameter int unsigned MAX_WAVE  = MAX_WAVE_DEF,
  parameter int unsigned MAX_PULSE = MAX_PULSE_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire llc_cmd_t                cmd,
  output      llc_stat_t               stat,
  // request payload
  input  wire logic [IDX_W-1:0]        req_index,
  input  wire logic signed [SMP_W-1:0] req_sample,
  // config writes
  input  wire logic                    cfg_valid,
  input  wire logic [REG_W-1:0]        cfg_index,
  input  wire logic [CDATA_W-1:0]      cfg_data,
  output      logic                    cfg_ready,
  // result register
  output      logic                    rsp_valid,
  input  wire logic                    rsp_ready,
  output      logic signed [VAL_W-1:0] rsp_value,
  output      logic [IDX_W-1:0]        rsp_out_index,
  output      logic [STAT_W-1:0]       rsp_status,
  output      logic                    rsp_saturated
);

  localparam int unsigned WA_W = $clog2(MAX_WAVE);
  localparam int unsigned PA_W = $clog2(MAX_PULSE);
  localparam logic [PSUM_W-1:0] ROUND_HALF = PSUM_W'(1) << (FRAC_SH - 1);

  // ---------------- configuration ----------------
  logic [WLEN_W-1:0]        wave_len;
  logic [PLEN_W-1:0]        pulse_len;
  logic signed [OFF_W-1:0]  offset;
  logic signed [GAIN_W-1:0] gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_len  <= WLEN_W'(1);
      pulse_len <= PLEN_W'(1);
      offset    <= '0;
      gain      <= GAIN_W'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_LEN:  wave_len  <= cfg_data[WLEN_W-1:0];
        REG_PULSE_LEN: pulse_len <= cfg_data[PLEN_W-1:0];
        REG_OFFSET:    offset    <= cfg_data[OFF_W-1:0];
        REG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // lengths clamped to store depth
  logic [WLEN_W-1:0] nw;
  logic [PLEN_W-1:0] np;
  assign nw = (32'(wave_len) > MAX_WAVE) ? WLEN_W'(MAX_WAVE) : wave_len;
  assign np = (32'(pulse_len) > MAX_PULSE) ? PLEN_W'(MAX_PULSE) : pulse_len;

  // ---------------- stores ----------------
  logic signed [SMP_W-1:0]  wave_mem  [MAX_WAVE];
  logic signed [COEF_W-1:0] pulse_mem [MAX_PULSE];
  logic signed [COEF_W-1:0] coef_in;
  logic [WA_W-1:0]          wave_addr;
  logic [PA_W-1:0]          pulse_addr;
  logic signed [SMP_W-1:0]  wave_rd;
  logic signed [COEF_W-1:0] pulse_rd;

  always_comb begin
    if (req_sample > 24'sd131071) begin
      coef_in = 18'sh1FFFF;
    end else if (req_sample < -24'sd131072) begin
      coef_in = 18'sh20000;
    end else begin
      coef_in = req_sample[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wave && 32'(req_index) < MAX_WAVE) begin
      wave_mem[WA_W'(req_index)] <= req_sample;
    end
    wave_rd <= wave_mem[wave_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pulse && 32'(req_index) < MAX_PULSE) begin
      pulse_mem[PA_W'(req_index)] <= coef_in;
    end
    pulse_rd <= pulse_mem[pulse_addr];
  end

  // ---------------- read setup and checks ----------------
  logic [IDX_W-1:0]        idx_r;
  logic [WLEN_W-1:0]       j;
  logic [STAT_W-1:0]       code_r;
  logic [STAT_W-1:0]       code;
  logic signed [IDX_W+1:0] last_out;
  logic                    err_long;
  logic                    err_range;

  assign err_long  = {1'b0, np} > nw;
  assign last_out  = $signed({2'b0, nw}) + $signed({3'b0, np}) - 15'sd1;
  assign err_range = $signed({2'b0, idx_r}) >= last_out;
  assign code      = err_long ? STAT_PULSE_LONG : (err_range ? STAT_RANGE : STAT_OK);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= req_index;
    end
    if (cmd.check) begin
      code_r <= code;
    end
  end

  // ---------------- MAC pipe ----------------
  logic signed [K_W-1:0]    k;
  logic                     k_ok;
  logic                     v1, v2, m1;
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  assign k = $signed({3'b0, idx_r}) - $signed({3'b0, j})
           + $signed({{(K_W-OFF_W){offset[OFF_W-1]}}, offset});
  assign k_ok       = !k[K_W-1] && (k < $signed({4'b0, np}));
  assign wave_addr  = WA_W'(j);
  assign pulse_addr = k[PA_W-1:0];
  assign mult       = wave_rd * pulse_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      j <= '0;
    end else if (cmd.issue) begin
      j <= j + WLEN_W'(1);
    end
    m1   <= k_ok;
    prod <= m1 ? mult : '0;
    if (cmd.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // ---------------- scaling: |sum| * |gain|, round, saturate ----------------
  logic [SUM_W-1:0]  acc_neg;
  logic [GAIN_W-1:0] gain_neg;
  logic [MAG_W-1:0]  mag_r;
  logic [GAIN_W-1:0] g_r;
  logic              neg_r;
  logic [PLO_W-1:0]  plo, plo_r;
  logic [PHI_W-1:0]  phi, phi_r;
  logic [PSUM_W-1:0] psum;
  logic [Q_W-1:0]    q_r;

  assign acc_neg  = '0 - acc;
  assign gain_neg = '0 - gain;
  assign plo      = mag_r[31:0] * g_r;
  assign phi      = mag_r[MAG_W-1:32] * g_r;
  assign psum     = {phi_r, 32'b0} + {{(PSUM_W-PLO_W){1'b0}}, plo_r} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      neg_r <= acc[SUM_W-1] ^ gain[GAIN_W-1];
      mag_r <= acc[SUM_W-1] ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];
      g_r   <= gain[GAIN_W-1] ? gain_neg : gain;
    end
    if (cmd.mul_en) begin
      plo_r <= plo;
      phi_r <= phi;
    end
    if (cmd.add_en) begin
      q_r <= psum[PSUM_W-1:FRAC_SH];
    end
  end

  logic                    neg_eff;
  logic                    sat_pos, sat_neg;
  logic [VAL_W-1:0]        mag32;
  logic [VAL_W-1:0]        val;

  assign neg_eff = neg_r && (q_r != '0);
  assign sat_pos = !neg_eff && (q_r > Q_W'(32'h7FFF_FFFF));
  assign sat_neg = neg_eff && (q_r > Q_W'(32'h8000_0000));
  assign mag32   = sat_pos ? 32'h7FFF_FFFF : (sat_neg ? 32'h8000_0000 : q_r[VAL_W-1:0]);
  assign val     = neg_eff ? ('0 - mag32) : mag32;

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_out_index <= idx_r;
      rsp_status    <= code_r;
      if (code_r == STAT_OK) begin
        rsp_value     <= val;
        rsp_saturated <= sat_pos || sat_neg;
      end else begin
        rsp_value     <= '0;
        rsp_saturated <= 1'b0;
      end
    end
  end

  // ---------------- status to controller ----------------
  always_comb begin
    stat.err       = code != STAT_OK;
    stat.last_j    = ({1'b0, j} + (WLEN_W+1)'(1)) == {1'b0, nw};
    stat.pipe_busy = v1 || v2;
    stat.rsp_free  = !rsp_valid || rsp_ready;
  end

endmodule

`default_nettype wire

>>> rtl/lagged_linear_convolution.sv
// ----------------------------------------------------------------------------
// lagged_linear_convolution
// Waveform/pulse convolution at one output index per read request.
// ----------------------------------------------------------------------------
// Usage:
//   req : op/index/sample. Loads (op 0 waveform, op 1 pulse) complete in the
//         transfer cycle. A read (op 2) asks for output index 'index'.
//   rsp : one result per read: value, out_index, status, saturated.
//   cfg : register writes (waveform_len, pulse_len, pulse_offset, gain),
//         always ready; write only while no read is in flight.
// Timing: a read walks waveform_len stored samples with one
//   multiply-accumulate per cycle; a read rejected with an error status
//   skips the sweep and scaling. One read is in flight at a time; req is
//   not ready during a read.
// Reset: config registers return to their defaults (lengths 1, offset 0,
//   gain 1.0). The sample stores are not cleared and must be loaded first.
// Stall: the result sits in an output register; loads are still taken while
//   it waits, and a following read stalls in its last step until the
//   result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lagged_linear_convolution_macros.svh"

module lagged_linear_convolution
  import llc_pkg::*;
#(
  parameter int unsigned MAX_WAVE  = MAX_WAVE_DEF,
  parameter int unsigned MAX_PULSE = MAX_PULSE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  llc_req_if.sink   req,
  llc_rsp_if.source rsp,
  llc_cfg_if.sink   cfg
);

  llc_cmd_t  cmd;
  llc_stat_t stat;

  llc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  llc_dp #(
    .MAX_WAVE  (MAX_WAVE),
    .MAX_PULSE (MAX_PULSE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_index     (req.index),
    .req_sample    (req.sample),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .cfg_ready     (cfg.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value     (rsp.value),
    .rsp_out_index (rsp.out_index),
    .rsp_status    (rsp.status),
    .rsp_saturated (rsp.saturated)
  );

  // request side only opens once the MAC pipe has drained
  `LLC_ASSERT_IMPL(a_ready_pipe_empty, clk, rst, req.ready, !stat.pipe_busy)
  // a sweep step always has a product in flight next cycle
  `LLC_ASSERT_NEXT(a_issue_fills_pipe, clk, rst, cmd.issue, stat.pipe_busy)
  // results are only loaded into a free output register
  `LLC_ASSERT_IMPL(a_emit_slot_free, clk, rst, cmd.emit, stat.rsp_free)
  // error results carry zero value and no saturation flag
  `LLC_ASSERT_IMPL(a_err_zero, clk, rst, rsp.valid && rsp.status != STAT_OK,
                   rsp.value == '0 && !rsp.saturated)

endmodule

`default_nettype wire
